### src/lrd_pkg.sv
// lrd_pkg: shared types, constants and rounding helpers for the listener
// relative direction block. No dependencies.
`timescale 1ns / 1ps
package lrd_pkg;

  localparam int QDEPTH = 8;
  localparam int QAW    = 3;
  localparam int QCW    = 4;

  localparam logic [16:0] MIN_LENGTH_RESET = 17'd7;
  localparam logic [31:0] ONE_Q30          = 32'h4000_0000;
  localparam logic [16:0] OUT_MAX          = 17'd16384;

  // One vector: component magnitudes, signs and the degenerate mark
  typedef struct packed {
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic             degen;
  } vec_t;

  typedef struct packed {
    vec_t off;
    vec_t fwd;
    vec_t upv;
  } item_t;

  // Round v / 2^30 to nearest, ties away from zero
  function automatic logic signed [33:0] rnd_q30(input logic signed [64:0] v);
    logic [64:0] m;
    logic [64:0] r;
    m = v[64] ? 65'(-v) : 65'(v);
    r = (m + (65'(1) << 29)) >> 30;
    rnd_q30 = v[64] ? -$signed(r[33:0]) : $signed(r[33:0]);
  endfunction

  // Round v / 2^46 to nearest, ties away from zero, saturate to +-16384
  function automatic logic [15:0] rnd_out(input logic signed [67:0] v);
    logic [67:0] m;
    logic [67:0] r;
    logic [16:0] s;
    m = v[67] ? 68'(-v) : 68'(v);
    r = (m + (68'(1) << 45)) >> 46;
    s = (r > 68'(OUT_MAX)) ? OUT_MAX : r[16:0];
    rnd_out = v[67] ? 16'(-s) : 16'(s);
  endfunction

endpackage

### src/lrd_front.sv
// lrd_front: accepts input beats, forms offset/forward/up magnitudes and
// flags degenerate vectors. Depends on lrd_pkg.
`timescale 1ns / 1ps
module lrd_front import lrd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [383:0]     in_tdata,
  input  logic             min_length_we,
  input  logic [16:0]      min_length_wdata,
  input  logic [QCW-1:0]   q_count,
  output logic             push,
  output item_t            push_data
);

  logic [16:0] min_length;
  logic [33:0] min_sq;

  logic        v1, v2, v3;
  vec_t        vin [3];
  vec_t        vec1 [3];
  vec_t        vec2 [3];
  logic [2:0]  small2, zero2;
  logic [33:0] sq2 [3][3];
  item_t       item3;
  logic        accept;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (q_count + QCW'(v1) + QCW'(v2) + QCW'(v3)) < QCW'(QDEPTH);

  always_comb begin
    logic signed [32:0] d;
    logic [31:0]        f;
    for (int a = 0; a < 3; a++) begin
      d = 33'($signed(in_tdata[32*(9+a) +: 32])) - 33'($signed(in_tdata[32*a +: 32]));
      vin[0].neg[a] = d[32];
      vin[0].mag[a] = d[32] ? 32'(-d) : d[31:0];
      f = in_tdata[32*(3+a) +: 32];
      vin[1].neg[a] = f[31];
      vin[1].mag[a] = f[31] ? -f : f;
      f = in_tdata[32*(6+a) +: 32];
      vin[2].neg[a] = f[31];
      vin[2].mag[a] = f[31] ? -f : f;
    end
    for (int b = 0; b < 3; b++) vin[b].degen = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= MIN_LENGTH_RESET;
    end else if (min_length_we) begin
      min_length <= min_length_wdata;
    end
    min_sq <= min_length * min_length;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
    vec1 <= vin;
    vec2 <= vec1;
    for (int b = 0; b < 3; b++) begin
      small2[b] <= (vec1[b].mag[0][31:17] == 15'd0) && (vec1[b].mag[1][31:17] == 15'd0)
                   && (vec1[b].mag[2][31:17] == 15'd0);
      zero2[b]  <= (vec1[b].mag[0] == 32'd0) && (vec1[b].mag[1] == 32'd0)
                   && (vec1[b].mag[2] == 32'd0);
      for (int c = 0; c < 3; c++) begin
        sq2[b][c] <= vec1[b].mag[c][16:0] * vec1[b].mag[c][16:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [35:0] s;
    logic        dg [3];
    for (int b = 0; b < 3; b++) begin
      s = 36'(sq2[b][0]) + 36'(sq2[b][1]) + 36'(sq2[b][2]);
      dg[b] = zero2[b] || (small2[b] && (s < 36'(min_sq)));
    end
    item3.off       <= '{mag: vec2[0].mag, neg: vec2[0].neg, degen: dg[0]};
    item3.fwd       <= '{mag: vec2[1].mag, neg: vec2[1].neg, degen: dg[1]};
    item3.upv       <= '{mag: vec2[2].mag, neg: vec2[2].neg, degen: dg[2]};
  end

  assign push      = v3;
  assign push_data = item3;

endmodule

### src/lrd_queue.sv
// lrd_queue: short FIFO of classified items between front and back.
// Depends on lrd_pkg.
`timescale 1ns / 1ps
module lrd_queue import lrd_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  item_t          push_data,
  input  logic           pop,
  output logic           q_valid,
  output item_t          q_data,
  output logic [QCW-1:0] count
);

  item_t          mem [QDEPTH];
  logic [QAW-1:0] wp, rp;

  assign q_valid = count != '0;
  assign q_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + QAW'(1);
      if (pop) rp <= rp + QAW'(1);
      count <= count + QCW'(push) - QCW'(pop);
    end
    if (push) mem[wp] <= push_data;
  end

endmodule

### src/lrd_norm.sv
// lrd_norm: pipelined vector normalizer (scale, square root, restoring
// division) producing a Q1.30 unit vector. Depends on lrd_pkg.
`timescale 1ns / 1ps
module lrd_norm import lrd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  vec_t             in_vec,
  output logic             out_valid,
  output logic [2:0][31:0] out_unit,
  output logic             out_degen
);

  // scale stages
  logic             s1_v, s2_v;
  logic [2:0][31:0] s1_m;
  logic [2:0]       s1_neg, s2_neg, s3_neg;
  logic             s1_deg, s2_deg, s3_deg;
  logic             s1_rsh;
  logic [4:0]       s1_lsh;
  logic [2:0][30:0] s2_m, s3_m;
  logic             s3_v;
  logic [2:0][61:0] s3_sq;

  logic [31:0] or_all;
  logic [4:0]  pos;

  always_comb begin
    or_all = in_vec.mag[0] | in_vec.mag[1] | in_vec.mag[2];
    pos    = '0;
    for (int i = 0; i < 32; i++) begin
      if (or_all[i]) pos = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
    if (en) begin
      s1_m   <= in_vec.mag;
      s1_neg <= in_vec.neg;
      s1_deg <= in_vec.degen;
      s1_rsh <= pos == 5'd31;
      s1_lsh <= (pos == 5'd31) ? 5'd0 : 5'd30 - pos;
      for (int i = 0; i < 3; i++) begin
        s2_m[i] <= s1_rsh ? s1_m[i][31:1] : 31'(s1_m[i] << s1_lsh);
        s3_sq[i] <= s2_m[i] * s2_m[i];
      end
      s2_neg <= s1_neg;
      s2_deg <= s1_deg;
      s3_m   <= s2_m;
      s3_neg <= s2_neg;
      s3_deg <= s2_deg;
    end
  end

  // square root, one result bit per stage
  logic [63:0]      sq_x    [33];
  logic [35:0]      sq_rem  [33];
  logic [31:0]      sq_root [33];
  logic [2:0][30:0] sq_m    [33];
  logic [2:0]       sq_neg  [33];
  logic             sq_deg  [33];
  logic             sq_v    [33];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= s3_v;
    end
    if (en) begin
      sq_x[0]    <= 64'(s3_sq[0]) + 64'(s3_sq[1]) + 64'(s3_sq[2]);
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_m[0]    <= s3_m;
      sq_neg[0]  <= s3_neg;
      sq_deg[0]  <= s3_deg;
    end
  end

  for (genvar k = 0; k < 32; k++) begin : g_sqrt
    logic [35:0] rem_sh;
    logic [35:0] trial;
    assign rem_sh = {sq_rem[k][33:0], sq_x[k][2*(31-k)+1 -: 2]};
    assign trial  = {2'b00, sq_root[k], 2'b01};
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (en) begin
        sq_v[k+1] <= sq_v[k];
      end
      if (en) begin
        sq_x[k+1]   <= sq_x[k];
        sq_m[k+1]   <= sq_m[k];
        sq_neg[k+1] <= sq_neg[k];
        sq_deg[k+1] <= sq_deg[k];
        if (rem_sh >= trial) begin
          sq_rem[k+1]  <= rem_sh - trial;
          sq_root[k+1] <= {sq_root[k][30:0], 1'b1};
        end else begin
          sq_rem[k+1]  <= rem_sh;
          sq_root[k+1] <= {sq_root[k][30:0], 1'b0};
        end
      end
    end
  end

  // division of (m * 2^30 + L/2) by L, one quotient bit per stage
  logic [2:0][31:0] dv_rem [32];
  logic [2:0][30:0] dv_n   [32];
  logic [2:0][30:0] dv_q   [32];
  logic [31:0]      dv_l   [32];
  logic [2:0]       dv_neg [32];
  logic             dv_deg [32];
  logic             dv_v   [32];

  always_ff @(posedge clk) begin
    logic [61:0] n;
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= sq_v[32];
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n = {1'b0, sq_m[32][i], 30'd0} + 62'(sq_root[32][31:1]);
        dv_rem[0][i] <= 32'(n[61:31]);
        dv_n[0][i]   <= n[30:0];
        dv_q[0][i]   <= '0;
      end
      dv_l[0]   <= sq_root[32];
      dv_neg[0] <= sq_neg[32];
      dv_deg[0] <= sq_deg[32];
    end
  end

  for (genvar j = 0; j < 31; j++) begin : g_div
    logic [2:0][32:0] r;
    logic [2:0]       ge;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        r[i]  = {dv_rem[j][i], dv_n[j][i][30-j]};
        ge[i] = r[i] >= {1'b0, dv_l[j]};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else if (en) begin
        dv_v[j+1] <= dv_v[j];
      end
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem[j+1][i] <= ge[i] ? 32'(r[i] - {1'b0, dv_l[j]}) : r[i][31:0];
          dv_q[j+1][i]   <= dv_q[j][i] | (31'(ge[i]) << (30 - j));
        end
        dv_n[j+1]   <= dv_n[j];
        dv_l[j+1]   <= dv_l[j];
        dv_neg[j+1] <= dv_neg[j];
        dv_deg[j+1] <= dv_deg[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_v[31];
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        out_unit[i] <= dv_neg[31][i] ? -32'(dv_q[31][i]) : 32'(dv_q[31][i]);
      end
      out_degen <= dv_deg[31];
    end
  end

endmodule

### src/lrd_back.sv
// lrd_back: normalizes the three vectors, forms the right axis and the
// projections, and holds the output register. Depends on lrd_pkg, lrd_norm.
`timescale 1ns / 1ps
module lrd_back import lrd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  item_t       q_data,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata
);

  logic en;
  assign en    = !out_tvalid || out_tready;
  assign q_pop = en && q_valid;

  logic             nv;
  logic [2:0][31:0] t_u, f_u, u_u;
  logic             t_dg, f_dg, u_dg;

  lrd_norm u_norm_off (
    .clk(clk), .rst(rst), .en(en), .in_valid(q_valid), .in_vec(q_data.off),
    .out_valid(nv), .out_unit(t_u), .out_degen(t_dg)
  );
  lrd_norm u_norm_fwd (
    .clk(clk), .rst(rst), .en(en), .in_valid(q_valid), .in_vec(q_data.fwd),
    .out_valid(), .out_unit(f_u), .out_degen(f_dg)
  );
  lrd_norm u_norm_up (
    .clk(clk), .rst(rst), .en(en), .in_valid(q_valid), .in_vec(q_data.upv),
    .out_valid(), .out_unit(u_u), .out_degen(u_dg)
  );

  // substitute default axes
  logic signed [31:0] t0 [3], f0 [3], u0 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t0[i] = $signed(t_u[i]);
      f0[i] = f_dg ? ((i == 2) ? $signed(ONE_Q30) : 32'sd0) : $signed(f_u[i]);
      u0[i] = u_dg ? ((i == 1) ? $signed(ONE_Q30) : 32'sd0) : $signed(u_u[i]);
    end
  end

  logic               b1_v, b2_v, b3_v, b4_v;
  logic               b1_td, b2_td, b3_td, b4_td;
  logic signed [31:0] b1_t [3], b1_f [3], b1_u [3];
  logic signed [31:0] b2_t [3], b2_f [3], b2_u [3];
  logic signed [63:0] b1_p [6];
  logic signed [33:0] b2_rt [3];
  logic signed [65:0] b3_pr [3];
  logic signed [63:0] b3_pu [3], b3_pf [3];
  logic signed [67:0] b4_s [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v       <= 1'b0;
      b2_v       <= 1'b0;
      b3_v       <= 1'b0;
      b4_v       <= 1'b0;
      out_tvalid <= 1'b0;
    end else if (en) begin
      b1_v       <= nv;
      b2_v       <= b1_v;
      b3_v       <= b2_v;
      b4_v       <= b3_v;
      out_tvalid <= b4_v;
    end
    if (en) begin
      // cross-product terms
      b1_t  <= t0;
      b1_f  <= f0;
      b1_u  <= u0;
      b1_td <= t_dg;
      b1_p[0] <= f0[1] * u0[2];
      b1_p[1] <= f0[2] * u0[1];
      b1_p[2] <= f0[2] * u0[0];
      b1_p[3] <= f0[0] * u0[2];
      b1_p[4] <= f0[0] * u0[1];
      b1_p[5] <= f0[1] * u0[0];
      // right axis
      b2_t  <= b1_t;
      b2_f  <= b1_f;
      b2_u  <= b1_u;
      b2_td <= b1_td;
      for (int i = 0; i < 3; i++) begin
        b2_rt[i] <= rnd_q30(65'(b1_p[2*i]) - 65'(b1_p[2*i+1]));
      end
      // projection products
      b3_td <= b2_td;
      for (int i = 0; i < 3; i++) begin
        b3_pr[i] <= b2_t[i] * b2_rt[i];
        b3_pu[i] <= b2_t[i] * b2_u[i];
        b3_pf[i] <= b2_t[i] * b2_f[i];
      end
      // sums
      b4_td   <= b3_td;
      b4_s[0] <= 68'(b3_pr[0]) + 68'(b3_pr[1]) + 68'(b3_pr[2]);
      b4_s[1] <= 68'(b3_pu[0]) + 68'(b3_pu[1]) + 68'(b3_pu[2]);
      b4_s[2] <= 68'(b3_pf[0]) + 68'(b3_pf[1]) + 68'(b3_pf[2]);
      // output register: coincident source points straight ahead
      if (b4_td) begin
        out_tdata <= {16'(OUT_MAX), 16'd0, 16'd0};
      end else begin
        out_tdata <= {rnd_out(b4_s[2]), rnd_out(b4_s[1]), rnd_out(b4_s[0])};
      end
    end
  end

endmodule

### src/listener_relative_direction.sv
// listener_relative_direction: top level joining front, queue and back.
// Depends on lrd_pkg, lrd_front, lrd_queue, lrd_back.
`timescale 1ns / 1ps
// Usage:
//   Input stream (in_*): one beat carries listener position, forward and up
//   vectors and source position, twelve signed Q16.16 words.
//   Output stream (out_*): one beat per input beat with the source direction
//   along right, up and forward as signed Q2.14, saturated to +-16384.
//   min_length_we/min_length_wdata set the Q16.16 degenerate-length
//   threshold; write only while the block is idle. Reset value is 7.
// Throughput: one beat per cycle while the output does not stall. The front
//   classifies in three stages and feeds an 8-entry queue; in_tready drops
//   once queued plus in-flight beats reach the queue depth.
// Pipeline: an input beat passes three front stages, one queue write, then
//   69 normalizer stages (four scale stages, the 32-step square-root
//   pipeline, one divider setup stage, the 31-step division pipeline and an
//   output stage) and five projection and output stages to the output beat.
// Stall: while out_tvalid is high and out_tready low the back pipeline holds;
//   the front keeps filling the queue until it is full.
// Reset: rst is synchronous and active high; it empties the queue and
//   clears all valid bits.
module listener_relative_direction import lrd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_tvalid,
  output logic         in_tready,
  // listener_x, listener_y, listener_z, forward_x, forward_y, forward_z,
  // upward_x, upward_y, upward_z, source_x, source_y, source_z (32 b each)
  input  logic [383:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // local_right, local_up, local_forward (16 b each)
  output logic [47:0]  out_tdata,
  input  logic         min_length_we,
  input  logic [16:0]  min_length_wdata
);

  logic           push, pop, q_valid;
  item_t          push_data, q_data;
  logic [QCW-1:0] q_count;

  // accept and classify
  lrd_front u_front (
    .clk(clk), .rst(rst), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .min_length_we(min_length_we),
    .min_length_wdata(min_length_wdata), .q_count(q_count),
    .push(push), .push_data(push_data)
  );

  // decouple front from back
  lrd_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .pop(pop),
    .q_valid(q_valid), .q_data(q_data), .count(q_count)
  );

  // normalize, project, drive the output beat
  lrd_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_data(q_data), .q_pop(pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCW'(QDEPTH))
    else $error("queue overfilled");

  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    in_tready |-> q_count < QCW'(QDEPTH))
    else $error("ready with full queue");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_tvalid |-> ($signed(out_tdata[15:0]) <= 16'sd16384)
      && ($signed(out_tdata[15:0]) >= -16'sd16384)
      && ($signed(out_tdata[31:16]) <= 16'sd16384)
      && ($signed(out_tdata[31:16]) >= -16'sd16384)
      && ($signed(out_tdata[47:32]) <= 16'sd16384)
      && ($signed(out_tdata[47:32]) >= -16'sd16384))
    else $error("output out of range");
`endif

endmodule
